// ----- hw/rtl/iemr_pkg.sv -----
// Shared types and constants for the ICMP echo reply matcher.
package iemr_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 4096;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned COUNT_MAX = (1 << COUNT_W) - 1;
  localparam int unsigned ACCEPT_LIMIT =
      (MAX_PACKET_BYTES < COUNT_MAX) ? MAX_PACKET_BYTES : COUNT_MAX;
  localparam logic [COUNT_W-1:0] LIMIT = COUNT_W'(ACCEPT_LIMIT);

  localparam logic [COUNT_W-1:0] POS_TTL = COUNT_W'(8);
  localparam logic [COUNT_W-1:0] POS_SRC_FIRST = COUNT_W'(12);
  localparam logic [COUNT_W-1:0] POS_SRC_LAST = COUNT_W'(15);
  localparam logic [COUNT_W-1:0] OFS_ID = COUNT_W'(4);
  localparam logic [COUNT_W-1:0] OFS_ID_LO = COUNT_W'(5);
  localparam logic [COUNT_W-1:0] OFS_SEQ = COUNT_W'(6);
  localparam logic [COUNT_W-1:0] OFS_SEQ_LO = COUNT_W'(7);
  localparam logic [COUNT_W-1:0] MIN_ICMP_BYTES = COUNT_W'(8);

  typedef enum logic [1:0] {
    REG_OWN_ID   = 2'd0,
    REG_EXP_SEQ  = 2'd1,
    REG_TARGET   = 2'd2,
    REG_REPLY_TY = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_MATCH     = 3'd0,
    ST_SHORT     = 3'd1,
    ST_NOT_REPLY = 3'd2,
    ST_ID_SEQ    = 3'd3,
    ST_SOURCE    = 3'd4
  } status_t;

  typedef struct packed {
    logic [15:0] own_identifier;
    logic [15:0] expected_sequence;
    logic [31:0] target_address;
    logic [7:0]  echo_reply_type;
  } cfg_regs_t;

  typedef struct packed {
    logic               done;
    logic [COUNT_W-1:0] byte_count;
    logic [3:0]         header_words;
    logic [7:0]         ttl;
    logic [31:0]        source;
    logic [7:0]         icmp_type;
    logic [15:0]        identifier;
    logic [15:0]        sequence_no;
  } pkt_view_t;

endpackage

// ----- hw/rtl/iemr_cfg_regs.sv -----
// Configuration register file for the ICMP echo reply matcher.
module iemr_cfg_regs
  import iemr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_regs_t   regs
);

  cfg_regs_t regs_r;

  assign cfg_ready = 1'b1;
  assign regs = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        REG_OWN_ID:   regs_r.own_identifier <= cfg_data[15:0];
        REG_EXP_SEQ:  regs_r.expected_sequence <= cfg_data[15:0];
        REG_TARGET:   regs_r.target_address <= cfg_data;
        REG_REPLY_TY: regs_r.echo_reply_type <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/iemr_capture.sv -----
// Per-packet byte counter and header field capture.
module iemr_capture
  import iemr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] packet_byte,
  input  logic       last_byte,
  output pkt_view_t  view
);

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [3:0]         hw_r, hw_nxt;
  logic [7:0]         ttl_r, ttl_nxt;
  logic [31:0]        src_r, src_nxt;
  logic [7:0]         type_r, type_nxt;
  logic [15:0]        id_r, id_nxt;
  logic [15:0]        seq_r, seq_nxt;

  logic               first;
  logic               take;
  logic [3:0]         hw_b;
  logic [7:0]         ttl_b;
  logic [31:0]        src_b;
  logic [7:0]         type_b;
  logic [15:0]        id_b;
  logic [15:0]        seq_b;
  logic [COUNT_W-1:0] icmp_at;
  logic [COUNT_W-1:0] cnt_adv;

  always_comb begin
    first = (count_r == '0);
    take  = (count_r < LIMIT);
    hw_b   = first ? '0 : hw_r;
    ttl_b  = first ? '0 : ttl_r;
    src_b  = first ? '0 : src_r;
    type_b = first ? '0 : type_r;
    id_b   = first ? '0 : id_r;
    seq_b  = first ? '0 : seq_r;

    hw_nxt = (take && first) ? packet_byte[3:0] : hw_b;
    icmp_at = {{(COUNT_W-6){1'b0}}, hw_nxt, 2'b00};

    ttl_nxt = (take && count_r == POS_TTL) ? packet_byte : ttl_b;
    src_nxt = (take && count_r >= POS_SRC_FIRST && count_r <= POS_SRC_LAST)
              ? {src_b[23:0], packet_byte} : src_b;
    type_nxt = (take && count_r == icmp_at) ? packet_byte : type_b;
    id_nxt = (take && (count_r == icmp_at + OFS_ID || count_r == icmp_at + OFS_ID_LO))
             ? {id_b[7:0], packet_byte} : id_b;
    seq_nxt = (take && (count_r == icmp_at + OFS_SEQ || count_r == icmp_at + OFS_SEQ_LO))
              ? {seq_b[7:0], packet_byte} : seq_b;

    cnt_adv = take ? count_r + COUNT_W'(1) : count_r;
    count_nxt = last_byte ? '0 : cnt_adv;

    view.done         = accept && last_byte;
    view.byte_count   = cnt_adv;
    view.header_words = hw_nxt;
    view.ttl          = ttl_nxt;
    view.source       = src_nxt;
    view.icmp_type    = type_nxt;
    view.identifier   = id_nxt;
    view.sequence_no  = seq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hw_r   <= hw_nxt;
      ttl_r  <= ttl_nxt;
      src_r  <= src_nxt;
      type_r <= type_nxt;
      id_r   <= id_nxt;
      seq_r  <= seq_nxt;
    end
  end

endmodule

// ----- hw/rtl/iemr_report.sv -----
// Packet classification and two-entry result buffer.
module iemr_report
  import iemr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  pkt_view_t   view,
  input  cfg_regs_t   regs,
  output logic        room,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  output logic [2:0]  out_tuser
);

  status_t     status;
  logic [COUNT_W-1:0] need;
  logic [42:0] res;
  logic [42:0] out_data_r, skid_data_r;
  logic        out_valid_r, skid_valid_r;
  logic        pop;

  always_comb begin
    need = {{(COUNT_W-6){1'b0}}, view.header_words, 2'b00} + MIN_ICMP_BYTES;
    if (view.byte_count < need) begin
      status = ST_SHORT;
    end else if (view.icmp_type != regs.echo_reply_type) begin
      status = ST_NOT_REPLY;
    end else if (view.identifier != regs.own_identifier ||
                 view.sequence_no != regs.expected_sequence) begin
      status = ST_ID_SEQ;
    end else if (view.source != regs.target_address) begin
      status = ST_SOURCE;
    end else begin
      status = ST_MATCH;
    end
    res = {status, view.source, view.ttl};
  end

  assign pop = out_valid_r && out_tready;
  assign room = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= view.done;
      end
    end else if (view.done) begin
      if (out_valid_r) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (view.done) begin
      if (out_valid_r) begin
        skid_data_r <= res;
      end else begin
        out_data_r <= res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r[39:0];
  assign out_tuser  = out_data_r[42:40];

endmodule

// ----- hw/rtl/icmp_echo_reply_matcher_unit.sv -----
// Top level of the ICMP echo reply matcher.
//
// Input stream: one byte of a received IPv4 packet per transaction, with
// in_tlast on the final byte. The IHL, TTL, source address and the ICMP
// type, identifier and sequence are captured as the bytes pass.
// Output stream: one transaction per packet, issued for its last byte,
// with the status in out_tuser and TTL and source address in out_tdata.
// Configuration: cfg_index selects identifier, sequence, target address or
// reply type; cfg_data carries the value. Write only while idle.
// Throughput is one byte per cycle while in_tready is high. The captured
// fields of the last byte feed the classifier combinationally, and its
// result is loaded into the output register, or the skid register if held.
// A stalled receiver parks one result in the output register and one in a
// skid register; bytes keep flowing until the skid register holds a result,
// then in_tready drops until an output transaction frees the skid register.
// Reset empties the result buffer, clears the byte count and sets all
// configuration registers to zero.
module icmp_echo_reply_matcher_unit
  import iemr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] packet_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] hop_limit, [39:8] source_address
  output logic [2:0]  out_tuser,  // [2:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_regs_t regs;
  pkt_view_t view;
  logic      room;
  logic      accept;

  assign in_tready = room;
  assign accept = in_tvalid && room;

  iemr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  iemr_capture u_capture (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .packet_byte (in_tdata),
    .last_byte   (in_tlast),
    .view        (view)
  );

  iemr_report u_report (
    .clk        (clk),
    .rst_n      (rst_n),
    .view       (view),
    .regs       (regs),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the ICMP echo reply matcher: packet streams vs. a built-in parser.
module tb_top
  import iemr_pkg::*;
();

  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PRESS_HOLD = 400;
  localparam int unsigned RANDOM_BYTES = 1750;
  localparam int unsigned MAX_LEN = 4300;
  localparam int unsigned N_DIR = 18;

  typedef struct packed {
    status_t     st;
    logic [7:0]  ttl;
    logic [31:0] src;
  } reply_t;

  typedef struct packed {
    bit          max_cfg;
    int unsigned len;
    logic [3:0]  ihl;
    logic [7:0]  ttl;
    logic [31:0] src;
    logic [7:0]  icmp_ty;
    logic [15:0] id;
    logic [15:0] seq;
    bit          fixed;
    reply_t      res;
  } pkt_desc_t;

  localparam reply_t NO_REPLY = '{ST_MATCH, 8'h00, 32'h0};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  // typed expectation travels with each byte so the monitor sees it at the handshake
  bit          drv_fixed;
  reply_t      drv_fixed_res;

  // parser state and settings
  logic [12:0] byte_pos = '0;
  logic [3:0]  ihl_q = '0;
  logic [7:0]  ttl_q = '0;
  logic [31:0] src_q = '0;
  logic [7:0]  type_q = '0;
  logic [15:0] id_q = '0;
  logic [15:0] seq_q = '0;
  logic [15:0] own_id_r = '0;
  logic [15:0] exp_seq_r = '0;
  logic [31:0] target_r = '0;
  logic [7:0]  reply_ty_r = '0;

  reply_t      pending_replies [$];
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;
  bit          press_req = 1'b0;

  pkt_desc_t dir_rows [N_DIR] = '{
    '{1'b0, 1, 4'd5, 8'h00, 32'h0, 8'h00, 16'h0, 16'h0, 1'b1, '{ST_SHORT, 8'h00, 32'h0}},
    '{1'b0, 28, 4'd5, 8'h40, 32'h0, 8'h00, 16'h0, 16'h0, 1'b1, '{ST_MATCH, 8'h40, 32'h0}},
    '{1'b0, 28, 4'd5, 8'hFF, 32'h0, 8'h08, 16'h0, 16'h0, 1'b1,
      '{ST_NOT_REPLY, 8'hFF, 32'h0}},
    '{1'b0, 28, 4'd5, 8'h01, 32'h0, 8'h00, 16'h8000, 16'h0, 1'b1,
      '{ST_ID_SEQ, 8'h01, 32'h0}},
    '{1'b0, 28, 4'd5, 8'h80, 32'h0, 8'h00, 16'h0, 16'h0001, 1'b1,
      '{ST_ID_SEQ, 8'h80, 32'h0}},
    '{1'b0, 28, 4'd5, 8'h40, 32'hC0A80001, 8'h00, 16'h0, 16'h0, 1'b1,
      '{ST_SOURCE, 8'h40, 32'hC0A80001}},
    '{1'b0, 27, 4'd5, 8'h40, 32'h0, 8'h08, 16'h1234, 16'h0, 1'b1,
      '{ST_SHORT, 8'h40, 32'h0}},
    '{1'b0, 9, 4'd5, 8'h7F, 32'h0, 8'h00, 16'h0, 16'h0, 1'b1, '{ST_SHORT, 8'h7F, 32'h0}},
    '{1'b1, 28, 4'd5, 8'h00, 32'hFFFFFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1,
      '{ST_MATCH, 8'h00, 32'hFFFFFFFF}},
    '{1'b0, 68, 4'd15, 8'h22, 32'hFFFFFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, NO_REPLY},
    '{1'b0, 67, 4'd15, 8'h23, 32'hFFFFFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, NO_REPLY},
    '{1'b0, 20, 4'd0, 8'h24, 32'hFFFFFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, NO_REPLY},
    '{1'b0, 16, 4'd1, 8'h25, 32'hFFFFFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, NO_REPLY},
    '{1'b0, 24, 4'd4, 8'h26, 32'hFFFFFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, NO_REPLY},
    '{1'b0, 4100, 4'd5, 8'h27, 32'hFFFFFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, NO_REPLY},
    '{1'b0, 4096, 4'd5, 8'h28, 32'h0A000001, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, NO_REPLY},
    '{1'b0, 8, 4'd5, 8'h29, 32'hFFFFFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, NO_REPLY},
    '{1'b0, 36, 4'd5, 8'h2A, 32'hFFFFFFFF, 8'h00, 16'hFFFF, 16'hFFFF, 1'b0, NO_REPLY}
  };

  icmp_echo_reply_matcher_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic bit parse_byte(input logic [7:0] b, input logic last, output reply_t r);
    logic [12:0] icmp_at;
    logic [12:0] need;
    status_t     st;
    r = NO_REPLY;
    if (byte_pos == '0) begin
      ihl_q = '0;
      ttl_q = '0;
      src_q = '0;
      type_q = '0;
      id_q = '0;
      seq_q = '0;
    end
    if (byte_pos < LIMIT) begin
      if (byte_pos == 13'd0) ihl_q = b[3:0];
      if (byte_pos == POS_TTL) ttl_q = b;
      if (byte_pos >= POS_SRC_FIRST && byte_pos <= POS_SRC_LAST) src_q = {src_q[23:0], b};
      icmp_at = {7'd0, ihl_q, 2'b00};
      if (byte_pos == icmp_at) type_q = b;
      if (byte_pos == icmp_at + 13'd4 || byte_pos == icmp_at + 13'd5) id_q = {id_q[7:0], b};
      if (byte_pos == icmp_at + 13'd6 || byte_pos == icmp_at + 13'd7) seq_q = {seq_q[7:0], b};
      byte_pos = byte_pos + 13'd1;
    end
    if (!last) return 1'b0;
    need = {7'd0, ihl_q, 2'b00} + 13'd8;
    if (byte_pos < need) st = ST_SHORT;
    else if (type_q != reply_ty_r) st = ST_NOT_REPLY;
    else if (id_q != own_id_r || seq_q != exp_seq_r) st = ST_ID_SEQ;
    else if (src_q != target_r) st = ST_SOURCE;
    else st = ST_MATCH;
    r = '{st, ttl_q, src_q};
    byte_pos = '0;
    return 1'b1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 50)
      $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    reply_t r;
    if (rst_n && in_tvalid && in_tready) begin
      if (parse_byte(in_tdata, in_tlast, r))
        pending_replies.push_back(drv_fixed ? drv_fixed_res : r);
    end
  end

  always @(posedge clk) begin
    reply_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected transaction", {29'd0, out_tuser}, '0);
      end else begin
        e = pending_replies.pop_front();
        if (out_tuser != e.st) report_mismatch("status", {29'd0, out_tuser}, {29'd0, e.st});
        if (out_tdata[7:0] != e.ttl) report_mismatch("hop_limit", {24'd0, out_tdata[7:0]},
                                                      {24'd0, e.ttl});
        if (out_tdata[39:8] != e.src) report_mismatch("source_address", out_tdata[39:8], e.src);
      end
    end
  end

  initial begin
    int unsigned s;
    out_tready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (press_req) begin
        out_tready <= 1'b0;
        repeat (PRESS_HOLD) @(posedge clk);
        press_req = 1'b0;
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        s = pick_gap();
        if (s > 0) begin
          out_tready <= 1'b0;
          repeat (s) @(posedge clk);
        end
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last, input bit fixed,
                           input reply_t res, input bit burst);
    int unsigned gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    drv_fixed <= fixed;
    drv_fixed_res <= res;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_packet(input pkt_desc_t p, input bit burst);
    logic [7:0]  pkt [0:MAX_LEN-1];
    int unsigned at;
    for (int unsigned i = 0; i < p.len; i++) pkt[i] = 8'($urandom_range(0, 255));
    at = p.ihl * 4;
    if (at < p.len) pkt[at] = p.icmp_ty;
    if (at + 4 < p.len) pkt[at + 4] = p.id[15:8];
    if (at + 5 < p.len) pkt[at + 5] = p.id[7:0];
    if (at + 6 < p.len) pkt[at + 6] = p.seq[15:8];
    if (at + 7 < p.len) pkt[at + 7] = p.seq[7:0];
    pkt[0] = {4'h4, p.ihl};
    if (p.len > 8) pkt[8] = p.ttl;
    for (int unsigned i = 12; i < 16 && i < p.len; i++) pkt[i] = p.src[8*(15-i) +: 8];
    for (int unsigned i = 0; i < p.len; i++)
      send_byte(pkt[i], i == p.len - 1, p.fixed, p.res, burst);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_put(input cfg_index_t idx, input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_OWN_ID:   own_id_r = v[15:0];
      REG_EXP_SEQ:  exp_seq_r = v[15:0];
      REG_TARGET:   target_r = v;
      REG_REPLY_TY: reply_ty_r = v[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] id, input logic [15:0] seq,
                            input logic [31:0] tgt, input logic [7:0] ty);
    cfg_put(REG_OWN_ID, {16'd0, id});
    cfg_put(REG_EXP_SEQ, {16'd0, seq});
    cfg_put(REG_TARGET, tgt);
    cfg_put(REG_REPLY_TY, {24'd0, ty});
    cfg_valid <= 1'b0;
  endtask

  task automatic load_random_settings();
    int unsigned mode;
    mode = $urandom_range(0, 5);
    if (mode == 0) set_config('0, '0, '0, '0);
    else if (mode == 1) set_config('1, '1, '1, '1);
    else set_config(16'($urandom), 16'($urandom), $urandom,
                    ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'h00);
  endtask

  function automatic pkt_desc_t make_random_pkt();
    pkt_desc_t   p;
    int unsigned need;
    int unsigned kind;
    p.max_cfg = 1'b0;
    p.fixed = 1'b0;
    p.res = NO_REPLY;
    p.ihl = ($urandom_range(0, 9) < 7) ? 4'd5 : 4'($urandom_range(0, 15));
    need = p.ihl * 4 + 8;
    p.len = ((need > 16) ? need : 16) + (($urandom_range(0, 3) == 0) ?
            $urandom_range(0, 40) : $urandom_range(0, 6));
    p.ttl = 8'($urandom);
    p.src = target_r;
    p.icmp_ty = reply_ty_r;
    p.id = own_id_r;
    p.seq = exp_seq_r;
    kind = $urandom_range(0, 9);
    case (kind)
      4: p.len = $urandom_range(1, need - 1);
      5: p.icmp_ty ^= 8'(1 << $urandom_range(0, 7));
      6: p.id ^= 16'(1 << $urandom_range(0, 15));
      7: p.seq ^= 16'(1 << $urandom_range(0, 15));
      8: p.src ^= 32'(1 << $urandom_range(0, 31));
      9: begin
        p.len = $urandom_range(1, 80);
        p.src = $urandom;
        p.icmp_ty = 8'($urandom);
        p.id = 16'($urandom);
        p.seq = 16'($urandom);
      end
      default: ;
    endcase
    return p;
  endfunction

  initial begin
    pkt_desc_t   p;
    int unsigned rand_bytes;
    int unsigned rand_pkts;
    int unsigned press_left;
    bit          burst;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_OWN_ID;
    cfg_data = '0;
    drv_fixed = 1'b0;
    drv_fixed_res = NO_REPLY;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int unsigned i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].max_cfg) begin
        wait_drained();
        set_config('1, '1, '1, '1);
      end
      send_packet(dir_rows[i], 1'($urandom_range(0, 1)));
    end

    rand_bytes = 0;
    rand_pkts = 0;
    press_left = 0;
    while (rand_bytes < RANDOM_BYTES) begin
      if (rand_pkts % 12 == 0) begin
        wait_drained();
        load_random_settings();
      end
      if (rand_pkts == 14) begin
        press_req = 1'b1;
        press_left = 8;
      end
      burst = (press_left > 0) || ($urandom_range(0, 3) == 0);
      if (press_left > 0) press_left--;
      p = make_random_pkt();
      send_packet(p, burst);
      rand_bytes += p.len;
      rand_pkts++;
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
